// File: rtl/core/linked_list_queue_manager_defines.svh
// Assertion helpers for the queue manager.
`ifndef LINKED_LIST_QUEUE_MANAGER_DEFINES_SVH
`define LINKED_LIST_QUEUE_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LLQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/llq_pkg.sv
package llq_pkg;

  localparam int NUM_NODES  = 256;
  localparam int NUM_QUEUES = 4;
  localparam int DATA_WIDTH = 32;

  localparam int NW = $clog2(NUM_NODES);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int CW = $clog2(NUM_NODES + 1);
  localparam int OW = $clog2(NUM_QUEUES + 1);

  typedef logic [NW-1:0]         node_t;
  typedef logic [QW-1:0]         qid_t;
  typedef logic [CW-1:0]         cnt_t;
  typedef logic [OW-1:0]         own_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_MOVE_OWN   = 3'd3,
    OP_MOVE_OTHER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_NOT_MEMBER = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_LINK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // queue descriptor as read from the queue table
  typedef struct packed {
    node_t head;
    node_t tail;
    cnt_t  len;
  } qdesc_t;

  // queue table write request
  typedef struct packed {
    logic   we;
    qid_t   idx;
    qdesc_t desc;
  } qwr_t;

endpackage

// File: rtl/core/llq_ram.sv
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/llq_qtab.sv
module llq_qtab import llq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qid_t   raddr,
  output qdesc_t rd,
  input  qwr_t   wr
);

  node_t head_q [NUM_QUEUES];
  node_t tail_q [NUM_QUEUES];
  cnt_t  len_q  [NUM_QUEUES];

  assign rd = '{head: head_q[raddr], tail: tail_q[raddr], len: len_q[raddr]};

  // only lengths need reset; pointers are valid once length is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        len_q[i] <= '0;
      end
    end else if (wr.we) begin
      len_q[wr.idx] <= wr.desc.len;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      head_q[wr.idx] <= wr.desc.head;
      tail_q[wr.idx] <= wr.desc.tail;
    end
  end

endmodule

// File: rtl/core/linked_list_queue_manager.sv
// Channel | handshake          | payload
// --------+--------------------+-----------------------------------------------
// in      | in_valid/in_stall  | op, queue_id, dest_queue_id, node_handle,
//         |                    | item_data
// out     | out_valid/out_stall| status, result_node, result_data
//
// Each beat passes through IDLE, LOAD and DONE; a move that relinks adds
// LINK, set by the single write port of the link memories.
// Link, payload and owner stores are synchronous RAMs read in IDLE.
// Reset: sync, active high; clears queue lengths, free list counts and the
// owner valid bits (an owner entry never written reads as free).
// A result waiting on out_stall does not block intake; in_stall is high outside
// IDLE, and DONE holds while it finds the output register still full.
module linked_list_queue_manager import llq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            op,
  input  logic [1:0]            queue_id,
  input  logic [1:0]            dest_queue_id,
  input  logic [7:0]            node_handle,
  input  logic [DATA_WIDTH-1:0] item_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [7:0]            result_node,
  output logic [DATA_WIDTH-1:0] result_data
);

  `include "linked_list_queue_manager_defines.svh"

  state_t state, state_next;

  // latched beat
  logic [2:0] op_r;
  qid_t       q_r;
  qid_t       dq_r, dq_r_next;
  node_t      h_r;
  data_t      data_r;

  // free list
  node_t free_head, free_head_next;
  cnt_t  free_count, free_count_next;
  cnt_t  fresh_next, fresh_next_next;

  // pending result
  status_t res_status, res_status_next;
  node_t   res_node, res_node_next;
  data_t   res_data, res_data_next;

  // owner valid bits, cleared at reset
  logic [NUM_NODES-1:0] own_vld;
  logic                 own_vld_rd;

  // memory ports
  node_t rd_node;
  node_t nxt_q, prv_q;
  data_t pay_q;
  own_t  own_q, own_rd;
  logic  nxt_we, prv_we, pay_we, own_we;
  node_t nxt_wa, prv_wa, pay_wa, own_wa;
  node_t nxt_wd, prv_wd;
  own_t  own_wd;

  // queue table
  qid_t   qsel;
  qdesc_t qd;
  qwr_t   qwr;

  logic  accept;
  qid_t  dq_eff;
  node_t nx, pv, n;
  logic  got;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign qsel = (state == S_IDLE) ? qid_t'(queue_id) :
                (state == S_LINK) ? dq_r : q_r;

  // read address chosen from the incoming beat
  always_comb begin
    case (op_t'(op))
      OP_APPEND, OP_INSERT: rd_node = free_head;
      OP_REMOVE:            rd_node = qd.head;
      default:              rd_node = node_t'(node_handle);
    endcase
  end

  llq_qtab u_qtab (
    .clk   (clk),
    .rst   (rst),
    .raddr (qsel),
    .rd    (qd),
    .wr    (qwr)
  );

  llq_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(rd_node), .rdata(nxt_q)
  );

  llq_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(rd_node), .rdata(prv_q)
  );

  llq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_NODES)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(data_r), .raddr(rd_node), .rdata(pay_q)
  );

  llq_ram #(.WIDTH(OW), .DEPTH(NUM_NODES)) u_own_ram (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd), .raddr(rd_node), .rdata(own_q)
  );

  assign own_rd = own_vld_rd ? own_q : '0;
  assign nx     = nxt_q;
  assign pv     = prv_q;
  assign dq_eff = (op_t'(op_r) == OP_MOVE_OWN) ? q_r : dq_r;

  always_comb begin
    state_next      = state;
    dq_r_next       = dq_r;
    free_head_next  = free_head;
    free_count_next = free_count;
    fresh_next_next = fresh_next;
    res_status_next = res_status;
    res_node_next   = res_node;
    res_data_next   = res_data;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    pay_we = 1'b0; pay_wa = '0;
    own_we = 1'b0; own_wa = '0; own_wd = '0;
    qwr    = '0;
    n      = '0;
    got    = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOAD;
          dq_r_next  = qid_t'(dest_queue_id);
        end
      end

      S_LOAD: begin
        state_next      = S_DONE;
        res_status_next = ST_OK;
        res_node_next   = '0;
        res_data_next   = '0;
        case (op_t'(op_r))
          OP_APPEND, OP_INSERT: begin
            // recycled nodes first, then never-used ones in order
            if (free_count != '0) begin
              n               = free_head;
              got             = 1'b1;
              free_head_next  = nx;
              free_count_next = free_count - cnt_t'(1);
            end else if (fresh_next < cnt_t'(NUM_NODES)) begin
              n               = fresh_next[NW-1:0];
              got             = 1'b1;
              fresh_next_next = fresh_next + cnt_t'(1);
            end
            if (!got) begin
              res_status_next = ST_NO_FREE;
            end else begin
              res_node_next = n;
              pay_we = 1'b1; pay_wa = n;
              own_we = 1'b1; own_wa = n; own_wd = own_t'(q_r) + own_t'(1);
              qwr.we       = 1'b1;
              qwr.idx      = q_r;
              qwr.desc.len = qd.len + cnt_t'(1);
              if (qd.len == '0) begin
                qwr.desc.head = n;
                qwr.desc.tail = n;
              end else if (op_t'(op_r) == OP_APPEND) begin
                qwr.desc.head = qd.head;
                qwr.desc.tail = n;
                nxt_we = 1'b1; nxt_wa = qd.tail; nxt_wd = n;
                prv_we = 1'b1; prv_wa = n;       prv_wd = qd.tail;
              end else begin
                qwr.desc.head = n;
                qwr.desc.tail = qd.tail;
                prv_we = 1'b1; prv_wa = qd.head; prv_wd = n;
                nxt_we = 1'b1; nxt_wa = n;       nxt_wd = qd.head;
              end
            end
          end

          OP_REMOVE: begin
            if (qd.len == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              res_node_next = qd.head;
              res_data_next = pay_q;
              qwr.we        = 1'b1;
              qwr.idx       = q_r;
              qwr.desc.head = nx;
              qwr.desc.tail = (qd.tail == qd.head) ? pv : qd.tail;
              qwr.desc.len  = qd.len - cnt_t'(1);
              if (qd.tail != qd.head) begin
                prv_we = 1'b1; prv_wa = nx; prv_wd = pv;
              end
              // push onto the free list
              nxt_we = 1'b1; nxt_wa = qd.head; nxt_wd = free_head;
              own_we = 1'b1; own_wa = qd.head; own_wd = '0;
              free_head_next  = qd.head;
              free_count_next = free_count + cnt_t'(1);
            end
          end

          OP_MOVE_OWN, OP_MOVE_OTHER: begin
            res_node_next = h_r;
            if (own_rd != own_t'(q_r) + own_t'(1)) begin
              res_status_next = ST_NOT_MEMBER;
            end else if (!(dq_eff == q_r && qd.tail == h_r)) begin
              // unlink here, relink at the destination tail in LINK
              qwr.we        = 1'b1;
              qwr.idx       = q_r;
              qwr.desc.head = (qd.head == h_r) ? nx : qd.head;
              qwr.desc.tail = (qd.tail == h_r) ? pv : qd.tail;
              qwr.desc.len  = qd.len - cnt_t'(1);
              if (qd.head != h_r) begin
                nxt_we = 1'b1; nxt_wa = pv; nxt_wd = nx;
              end
              if (qd.tail != h_r) begin
                prv_we = 1'b1; prv_wa = nx; prv_wd = pv;
              end
              dq_r_next  = dq_eff;
              state_next = S_LINK;
            end
          end

          default: begin
            res_status_next = ST_NOT_MEMBER;
          end
        endcase
      end

      S_LINK: begin
        state_next   = S_DONE;
        qwr.we       = 1'b1;
        qwr.idx      = dq_r;
        qwr.desc.len = qd.len + cnt_t'(1);
        qwr.desc.tail = h_r;
        if (qd.len == '0) begin
          qwr.desc.head = h_r;
        end else begin
          qwr.desc.head = qd.head;
          nxt_we = 1'b1; nxt_wa = qd.tail; nxt_wd = h_r;
          prv_we = 1'b1; prv_wa = h_r;     prv_wd = qd.tail;
        end
        own_we = 1'b1; own_wa = h_r; own_wd = own_t'(dq_r) + own_t'(1);
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      fresh_next <= '0;
      own_vld    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      fresh_next <= fresh_next_next;
      if (own_we) begin
        own_vld[own_wa] <= 1'b1;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    own_vld_rd <= own_vld[rd_node];
    free_head  <= free_head_next;
    dq_r       <= dq_r_next;
    res_status <= res_status_next;
    res_node   <= res_node_next;
    res_data   <= res_data_next;
    if (accept) begin
      op_r   <= op;
      q_r    <= qid_t'(queue_id);
      h_r    <= node_t'(node_handle);
      data_r <= item_data;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status      <= res_status;
      result_node <= 8'(res_node);
      result_data <= res_data;
    end
  end

  `LLQ_ASSERT_IMPL(a_free_bound, 1'b1, free_count <= fresh_next, "free list exceeds nodes handed out")
  `LLQ_ASSERT_IMPL(a_fresh_bound, 1'b1, fresh_next <= cnt_t'(NUM_NODES), "fresh counter overran pool")
  `LLQ_ASSERT_IMPL(a_data_ok, out_valid && result_data != '0, status == ST_OK, "data on failed beat")
  `LLQ_ASSERT_NEXT(a_accept_load, in_valid && !in_stall, state == S_LOAD, "accept without load")

endmodule
